// File: hdl/stcct_pkg.sv
package stcct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 256;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_ADDR_W = 4;

   // register indexes
   localparam logic [1:0] REG_CHECK_ENABLE   = 2'd0;
   localparam logic [1:0] REG_STRICT_START   = 2'd1;
   localparam logic [1:0] REG_STRICT_TRIGGER = 2'd2;

   // request kinds
   localparam logic [1:0] FUNC_CHECK  = 2'd0;
   localparam logic [1:0] FUNC_RECORD = 2'd1;
   localparam logic [1:0] FUNC_EVENT  = 2'd2;

   // reason codes
   localparam logic [2:0] RSN_DISABLED = 3'd0;
   localparam logic [2:0] RSN_PASS     = 3'd1;
   localparam logic [2:0] RSN_BLOCKED  = 3'd2;
   localparam logic [2:0] RSN_WARN     = 3'd3;
   localparam logic [2:0] RSN_DONE     = 3'd4;
   localparam logic [2:0] RSN_FULL     = 3'd5;

   typedef enum logic [1:0] {
      OP_CHECK,
      OP_RECORD,
      OP_EVENT,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type              op;
      logic                record_ok;
      logic                event_ok;
      logic [63:0]         order_id;
      logic [31:0]         account_key;
      logic [31:0]         instrument_key;
      logic                order_side;
      logic signed [31:0]  price_ticks;
      logic [30:0]         order_volume;
      logic [30:0]         report_total;
      logic [30:0]         cum_filled;
      logic [1:0]          order_status;
   } item_type;

   typedef struct packed {
      logic [63:0]         order_id;
      logic [31:0]         account;
      logic [31:0]         instrument;
      logic                side;
      logic signed [31:0]  price;
      logic [30:0]         remaining;
      logic [30:0]         last_filled;
   } entry_type;

   typedef struct packed {
      logic        check_enable;
      logic [15:0] trigger_hits;
      logic        strict_load;
      logic        strict_value;
   } cfg_type;

   typedef struct packed {
      logic                reject;
      logic [2:0]          reason_code;
      logic signed [31:0]  observed_price;
      logic signed [31:0]  resting_price;
      logic                strict_now;
      logic [31:0]         hit_count;
   } rsp_type;

endpackage

// File: hdl/stcct_front.sv
module stcct_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [stcct_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [stcct_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            q_valid,
   output stcct_pkg::item_type             q_item,
   input  logic                            q_pop
);
   import stcct_pkg::*;

   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   item_type            item;
   logic                push;
   logic                pop;

   // classify the incoming beat
   always_comb begin
      item.order_id       = req_tdata[63:0];
      item.account_key    = req_tdata[95:64];
      item.instrument_key = req_tdata[127:96];
      item.order_side     = req_tdata[128];
      item.price_ticks    = req_tdata[160:129];
      item.order_volume   = req_tdata[191:161];
      item.report_total   = req_tdata[222:192];
      item.cum_filled     = req_tdata[253:223];
      item.order_status   = req_tdata[255:254];
      unique case (req_tuser)
         FUNC_CHECK:  item.op = OP_CHECK;
         FUNC_RECORD: item.op = OP_RECORD;
         FUNC_EVENT:  item.op = OP_EVENT;
         default:     item.op = OP_NONE;
      endcase
      item.record_ok = (item.order_id != '0) && (item.account_key != '0) &&
                       (item.instrument_key != '0) && (item.order_volume != '0);
      item.event_ok  = (item.order_id != '0);
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;
   assign q_valid    = (count_ff != '0);
   assign q_item     = q_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: hdl/stcct_back.sv
module stcct_back (
   input  logic                clock,
   input  logic                reset,
   input  stcct_pkg::cfg_type  cfg,
   input  logic                q_valid,
   input  stcct_pkg::item_type q_item,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output stcct_pkg::rsp_type  rsp
);
   import stcct_pkg::*;

   entry_type             mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   item_type              item_ff;
   logic                  rd_vld_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   entry_type             rd_entry_ff;
   logic                  hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   entry_type             hit_entry_ff, hit_entry_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  strict_ff, strict_in;
   logic [31:0]           hits_ff, hits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  start;
   logic                  finish;
   logic                  slot_v;
   logic                  crossing;
   logic                  match;
   logic [31:0]           hits_inc;
   logic [30:0]           rem_new;
   logic [30:0]           lf_new;
   logic [30:0]           delta;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   entry_type             wr_entry;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_SCAN;
         ST_SCAN:  if (cnt_ff == IDX_W'(TABLE_ENTRIES - 1)) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      start  = (state_ff == ST_IDLE) && q_valid;
      finish = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
      q_pop  = start;
      cnt_in = (state_ff == ST_SCAN) ? IDX_W'(cnt_ff + 1'b1) : '0;
   end

   // evaluate the slot read last cycle
   always_comb begin
      slot_v   = valid_ff[rd_idx_ff];
      crossing = (item_ff.order_side != rd_entry_ff.side) &&
                 (item_ff.order_side ? (item_ff.price_ticks <= rd_entry_ff.price)
                                     : (item_ff.price_ticks >= rd_entry_ff.price));
      if (item_ff.op == OP_CHECK) begin
         match = slot_v && (rd_entry_ff.remaining != '0) &&
                 (rd_entry_ff.account == item_ff.account_key) &&
                 (rd_entry_ff.instrument == item_ff.instrument_key) && crossing;
      end else begin
         match = slot_v && (rd_entry_ff.order_id == item_ff.order_id);
      end
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (start) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else if (rd_vld_ff) begin
         if (match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_entry_in = rd_entry_ff;
         end
         if (!slot_v && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end
   end

   // result and write-back
   always_comb begin
      hits_inc = (hits_ff == '1) ? hits_ff : hits_ff + 32'd1;
      delta    = item_ff.cum_filled - hit_entry_ff.last_filled;
      if (item_ff.report_total != '0) begin
         rem_new = (item_ff.report_total > item_ff.cum_filled) ?
                   item_ff.report_total - item_ff.cum_filled : '0;
      end else if (item_ff.cum_filled > hit_entry_ff.last_filled) begin
         rem_new = (hit_entry_ff.remaining > delta) ? hit_entry_ff.remaining - delta : '0;
      end else begin
         rem_new = hit_entry_ff.remaining;
      end
      lf_new = (item_ff.cum_filled > hit_entry_ff.last_filled) ?
               item_ff.cum_filled : hit_entry_ff.last_filled;

      strict_in    = strict_ff;
      hits_in      = hits_ff;
      valid_in     = valid_ff;
      wr_en        = 1'b0;
      wr_idx       = hit_idx_ff;
      wr_entry     = hit_entry_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cfg.strict_load) begin
         strict_in = cfg.strict_value;
      end

      if (finish) begin
         rsp_valid_in          = 1'b1;
         rsp_in.reject         = 1'b0;
         rsp_in.reason_code    = RSN_DONE;
         rsp_in.observed_price = '0;
         rsp_in.resting_price  = '0;
         unique case (item_ff.op)
            OP_CHECK: begin
               if (!cfg.check_enable) begin
                  rsp_in.reason_code = RSN_DISABLED;
               end else if (!hit_found_ff) begin
                  rsp_in.reason_code = RSN_PASS;
               end else begin
                  hits_in               = hits_inc;
                  rsp_in.observed_price = item_ff.price_ticks;
                  rsp_in.resting_price  = hit_entry_ff.price;
                  if (strict_ff || (cfg.trigger_hits == '0) ||
                      (hits_inc >= {16'b0, cfg.trigger_hits})) begin
                     strict_in          = 1'b1;
                     rsp_in.reject      = 1'b1;
                     rsp_in.reason_code = RSN_BLOCKED;
                  end else begin
                     rsp_in.reason_code = RSN_WARN;
                  end
               end
            end
            OP_RECORD: begin
               if (item_ff.record_ok) begin
                  if (hit_found_ff || free_found_ff) begin
                     wr_en                = 1'b1;
                     wr_idx               = hit_found_ff ? hit_idx_ff : free_idx_ff;
                     wr_entry.order_id    = item_ff.order_id;
                     wr_entry.account     = item_ff.account_key;
                     wr_entry.instrument  = item_ff.instrument_key;
                     wr_entry.side        = item_ff.order_side;
                     wr_entry.price       = item_ff.price_ticks;
                     wr_entry.remaining   = item_ff.order_volume;
                     wr_entry.last_filled = '0;
                     valid_in[wr_idx]     = 1'b1;
                  end else begin
                     rsp_in.reason_code = RSN_FULL;
                  end
               end
            end
            OP_EVENT: begin
               if (item_ff.event_ok && hit_found_ff) begin
                  wr_en                = 1'b1;
                  wr_entry.remaining   = rem_new;
                  wr_entry.last_filled = lf_new;
                  if ((item_ff.order_status != '0) || (rem_new == '0)) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         rsp_in.strict_now = strict_in;
         rsp_in.hit_count  = hits_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         strict_ff     <= 1'b0;
         hits_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= (state_ff == ST_SCAN);
         valid_ff      <= valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         strict_ff     <= strict_in;
         hits_ff       <= hits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= q_item;
      end
      rd_idx_ff    <= cnt_ff;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   // table memory: one read and one write port
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[cnt_ff];
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

// File: hdl/self_trade_cross_check_table_core.sv
// Self-trade prevention check table.
// req channel: one beat per item. tuser carries the function (check, record,
// event); tdata carries the order fields. rsp channel: exactly one beat per
// request, in request order, with the decision, prices, strict mode and hit
// count. csr: APB-style register port, pready always high; registers are
// check_enable (0x0), strict_at_start (0x4), strict_trigger_hits (0x8).
// Writing strict_at_start also loads the strict mode latch.
// Timing: each item scans the whole table through the single read port of
// the table memory, one slot per cycle, and then passes through a drain
// state and a done state to the response register; the engine takes a new
// item only after the last one's response has been registered.
// A two-beat input queue accepts new requests while the scan runs.
// Reset (synchronous) empties the table, clears the hit count and strict
// latch and restores register defaults. When rsp_tready is low the response
// holds, the scan engine waits at its result, and the input queue fills and
// then drops req_tready.
module self_trade_cross_check_table_core (
   input  logic                              clock,
   input  logic                              reset,
   // tuser: func[1:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: order_id[63:0], account_key[95:64], instrument_key[127:96],
   // order_side[128], price_ticks[160:129], order_volume[191:161],
   // report_total[222:192], cum_filled[253:223], order_status[255:254]
   input  logic [stcct_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [stcct_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: reject[0], reason_code[3:1], observed_price[35:4],
   // resting_price[67:36], strict_now[68], hit_count[100:69], zeros above
   output logic [stcct_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [stcct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import stcct_pkg::*;

   logic        check_enable_ff;
   logic        strict_start_ff;
   logic [15:0] trigger_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   cfg_type     cfg;
   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   rsp_type     rsp;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b1;
         strict_start_ff <= 1'b0;
         trigger_ff      <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CHECK_ENABLE:   check_enable_ff <= csr_pwdata[0];
            REG_STRICT_START:   strict_start_ff <= csr_pwdata[0];
            REG_STRICT_TRIGGER: trigger_ff      <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_CHECK_ENABLE:   csr_prdata = {31'b0, check_enable_ff};
         REG_STRICT_START:   csr_prdata = {31'b0, strict_start_ff};
         REG_STRICT_TRIGGER: csr_prdata = {16'b0, trigger_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.check_enable = check_enable_ff;
      cfg.trigger_hits = trigger_ff;
      cfg.strict_load  = csr_wr && (csr_idx == REG_STRICT_START);
      cfg.strict_value = csr_pwdata[0];
   end

   stcct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   stcct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {3'b0, rsp.hit_count, rsp.strict_now, rsp.resting_price,
                       rsp.observed_price, rsp.reason_code, rsp.reject};

endmodule

// File: hdl/stcct_checker.sv
module stcct_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [stcct_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import stcct_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // nothing pending right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // reject goes only with the blocked reason
   a_reject_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == RSN_BLOCKED)))
      else $error("reject and reason disagree");

   // prices only on a crossing
   a_price_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] != RSN_BLOCKED) && (rsp_tdata[3:1] != RSN_WARN)
      |-> (rsp_tdata[67:4] == '0))
      else $error("price reported without crossing");

   // reason code in range
   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:1] <= RSN_FULL))
      else $error("bad reason code");

endmodule

bind self_trade_cross_check_table_core stcct_checker u_stcct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
